// ----- sv/spq_pkg.sv -----
// spq_pkg: shared types and constants for the stable priority queue
// request and response beat structs, status codes, controller/datapath links
// no dependencies
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 16;
	localparam int PRIO_BITS_DEF   = 16;

	localparam int TAG_W  = 16;
	localparam int PRIO_W = 16;
	localparam int OCC_W  = 5;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} spq_req_type_t;

	typedef enum logic [1:0] {
		STS_INSERTED  = 2'd0,
		STS_REMOVED   = 2'd1,
		STS_UNDERFLOW = 2'd2,
		STS_FULL      = 2'd3
	} spq_status_t;

	typedef struct packed {
		spq_req_type_t     req_type;
		logic [TAG_W-1:0]  item_tag;
		logic [PRIO_W-1:0] item_priority;
	} spq_req_t;

	typedef struct packed {
		logic [TAG_W-1:0] removed_tag;
		spq_status_t      status;
		logic [OCC_W-1:0] occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic        load;
		logic        shift_in;
		logic        shift_out;
		spq_status_t code;
	} spq_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} spq_sts_t;

endpackage

// ----- sv/stable_priority_queue.sv -----
// stable_priority_queue: bounded priority queue with stable ordering
// top level joining spq_ctrl and spq_datapath
// depends on spq_pkg, spq_ctrl, spq_datapath
//
// Requests arrive on req (req_valid/req_stall) and each one gives exactly one
// response beat on rsp (rsp_valid/rsp_stall). An insert places its tag after
// every stored entry of lower or equal priority; a remove returns the front
// entry, the one with the lowest priority value. Removing from an empty queue
// reports underflow, an insert into a full queue is dropped and reported.
// The response is registered and valid in the cycle after the request beat.
// Throughput is one request per cycle while no response is held by rsp_stall;
// the row of cells compares and shifts in parallel.
// While rsp_stall holds a waiting response, req_stall is raised and the
// response stays put. Reset empties the queue and clears any held response;
// stored cell contents are not cleared, only the entry count.
module stable_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF,
	parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  spq_pkg::spq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	spq_cmd_t cmd;
	spq_sts_t sts;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req.req_type),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS),
		.PRIO_BITS   (PRIO_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	a_beat_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request gave no response");

	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_UNDERFLOW |-> rsp.occupancy == '0 &&
		rsp.removed_tag == '0)
		else $error("underflow response with nonzero fields");

	a_full_at_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_FULL |->
		rsp.occupancy == OCC_W'(QUEUE_DEPTH))
		else $error("full response below queue depth");

	a_no_flags_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_in && cmd.shift_out) && !(sts.empty && sts.full))
		else $error("conflicting queue command or status");

endmodule

// ----- sv/spq_ctrl.sv -----
// spq_ctrl: handshake controller for the stable priority queue
// decides the operation per beat and tracks the held response
// depends on spq_pkg
module spq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  spq_pkg::spq_req_type_t req_type,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	input  spq_pkg::spq_sts_t      sts,
	output spq_pkg::spq_cmd_t      cmd
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_HELD = 2'b10
	} spq_state_t;

	spq_state_t state_q;
	spq_state_t state_d;
	logic       accept;

	assign req_stall = (state_q == S_HELD) && rsp_stall;
	assign rsp_valid = (state_q == S_HELD);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept;
		cmd.code      = STS_INSERTED;
		if (req_type == REQ_REMOVE) begin
			cmd.shift_out = accept && !sts.empty;
			cmd.code      = sts.empty ? STS_UNDERFLOW : STS_REMOVED;
		end else begin
			cmd.shift_in  = accept && !sts.full;
			cmd.code      = sts.full ? STS_FULL : STS_INSERTED;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_HELD;
			end
			S_HELD: begin
				if (!rsp_stall && !accept) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/spq_datapath.sv -----
// spq_datapath: sorted row of queue cells, entry count and response register
// cells compare against the incoming priority in parallel and shift as commanded
// depends on spq_pkg
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = spq_pkg::TAG_BITS_DEF,
	parameter int PRIO_BITS   = spq_pkg::PRIO_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::spq_req_t req,
	input  spq_pkg::spq_cmd_t cmd,
	output spq_pkg::spq_sts_t sts,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [TAG_BITS-1:0]  tag_q  [QUEUE_DEPTH];
	logic [PRIO_BITS-1:0] prio_q [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]  tag_d  [QUEUE_DEPTH];
	logic [PRIO_BITS-1:0] prio_d [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] le;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	logic [TAG_BITS-1:0]  tag_in;
	logic [PRIO_BITS-1:0] prio_in;
	spq_rsp_t             rsp_q;

	assign tag_in    = TAG_BITS'(req.item_tag);
	assign prio_in   = PRIO_BITS'(req.item_priority);
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(QUEUE_DEPTH));

	// cells at or below the new priority keep their place
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le[i] = (CW'(i) < count_q) && (prio_q[i] <= prio_in);
		end
	end

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			tag_d[i]  = tag_q[i];
			prio_d[i] = prio_q[i];
			if (cmd.shift_out) begin
				if (i < QUEUE_DEPTH - 1) begin
					tag_d[i]  = tag_q[(i + 1) % QUEUE_DEPTH];
					prio_d[i] = prio_q[(i + 1) % QUEUE_DEPTH];
				end
			end else if (!le[i]) begin
				if (i == 0 || le[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
					tag_d[i]  = tag_in;
					prio_d[i] = prio_in;
				end else begin
					tag_d[i]  = tag_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
					prio_d[i] = prio_q[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.shift_in) begin
			count_d = count_q + 1'b1;
		end else if (cmd.shift_out) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_in || cmd.shift_out) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				tag_q[i]  <= tag_d[i];
				prio_q[i] <= prio_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.removed_tag <= cmd.shift_out ? TAG_W'(tag_q[0]) : '0;
			rsp_q.status      <= cmd.code;
			rsp_q.occupancy   <= OCC_W'(count_d);
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- sim/testbench.sv -----
// testbench for stable_priority_queue: directed and random request traffic
// against a sorted-list predictor, with random valid gaps and response stalls
// depends on spq_pkg and stable_priority_queue
module testbench;
	import spq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	spq_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	spq_rsp_t rsp;

	logic [TAG_W-1:0]  held_tags [DEPTH];
	logic [PRIO_W-1:0] held_prios[DEPTH];
	int                held_count = 0;

	spq_rsp_t pending_rsps[$];
	int       mismatches = 0;
	bit       req_idle   = 1'b1;
	bit       rsp_idle   = 1'b1;
	int       stall_left = 0;

	stable_priority_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("testbench NOT OK");
		$finish;
	end

	// sorted insert after equal priorities, remove from the front
	function automatic spq_rsp_t queue_apply(spq_req_t beat);
		spq_rsp_t r;
		int       pos;
		int       k;
		r = '0;
		if (beat.req_type == REQ_INSERT) begin
			if (held_count >= DEPTH) begin
				r.status = STS_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prios[pos] <= beat.item_priority)
					pos++;
				for (k = held_count; k > pos; k--) begin
					held_tags[k]  = held_tags[k-1];
					held_prios[k] = held_prios[k-1];
				end
				held_tags[pos]  = beat.item_tag;
				held_prios[pos] = beat.item_priority;
				held_count++;
				r.status = STS_INSERTED;
			end
		end else if (held_count == 0) begin
			r.status = STS_UNDERFLOW;
		end else begin
			r.removed_tag = held_tags[0];
			for (k = 1; k < held_count; k++) begin
				held_tags[k-1]  = held_tags[k];
				held_prios[k-1] = held_prios[k];
			end
			held_count--;
			r.status = STS_REMOVED;
		end
		r.occupancy = OCC_W'(held_count);
		return r;
	endfunction

	// called at a rising edge, returns at the edge that takes the beat
	task automatic send_beat(input spq_req_t beat);
		int gap;
		gap = req_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsps.insert(pending_rsps.size(), queue_apply(beat));
	endtask

	task automatic send_request(input spq_req_type_t kind, input logic [TAG_W-1:0] tag,
			input logic [PRIO_W-1:0] prio);
		spq_req_t beat;
		beat.req_type      = kind;
		beat.item_tag      = tag;
		beat.item_priority = prio;
		send_beat(beat);
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				$error("response beat with no request outstanding");
				mismatches++;
			end else begin
				spq_rsp_t exp_rsp;
				exp_rsp = pending_rsps.pop_front();
				if (rsp.removed_tag !== exp_rsp.removed_tag) begin
					$error("removed_tag expected %h got %h", exp_rsp.removed_tag,
						rsp.removed_tag);
					mismatches++;
				end
				if (rsp.status !== exp_rsp.status) begin
					$error("status expected %0d got %0d", exp_rsp.status, rsp.status);
					mismatches++;
				end
				if (rsp.occupancy !== exp_rsp.occupancy) begin
					$error("occupancy expected %0d got %0d", exp_rsp.occupancy,
						rsp.occupancy);
					mismatches++;
				end
			end
			stall_left = rsp_idle ? $urandom_range(0, 17) : 0;
		end else if (rsp_valid && stall_left > 0) begin
			stall_left--;
		end
		rsp_stall <= (stall_left != 0);
	end

	task automatic test_underflow();
		send_request(REQ_REMOVE, 16'hffff, 16'hffff);
		send_request(REQ_REMOVE, 16'h0000, 16'h0000);
	endtask

	// extremes and ties first, then fill up, push one more than fits and remove two
	task automatic test_fill_to_full();
		send_request(REQ_INSERT, 16'h0000, 16'h0000);
		send_request(REQ_INSERT, 16'hffff, 16'hffff);
		send_request(REQ_INSERT, 16'h0001, 16'hffff);
		send_request(REQ_INSERT, 16'h8000, 16'h0000);
		send_request(REQ_INSERT, 16'h1234, 16'h0100);
		send_request(REQ_INSERT, 16'h5678, 16'h0100);
		send_request(REQ_INSERT, 16'h9abc, 16'h0080);
		while (held_count < DEPTH)
			send_request(REQ_INSERT, TAG_W'($urandom), PRIO_W'($urandom_range(0, 3)));
		send_request(REQ_INSERT, 16'hffff, 16'h0000);
		send_request(REQ_REMOVE, 16'h5555, 16'haaaa);
		send_request(REQ_REMOVE, 16'haaaa, 16'h5555);
	endtask

	// runs that lean towards filling, draining or neither, so both ends are hit often
	task automatic test_random_traffic(input int n_items);
		spq_req_t beat;
		int       ins_pct;
		int       prio_mode;
		int       run_len;
		while (n_items > 0) begin
			run_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: ins_pct = 85;
				1: ins_pct = 15;
				default: ins_pct = 50;
			endcase
			prio_mode = $urandom_range(0, 2);
			req_idle  = ($urandom_range(0, 3) != 0);
			rsp_idle  = ($urandom_range(0, 3) != 0);
			repeat (run_len) begin
				beat.req_type = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE;
				beat.item_tag = TAG_W'($urandom);
				case (prio_mode)
					0: beat.item_priority = PRIO_W'($urandom_range(0, 3));
					1: beat.item_priority = PRIO_W'($urandom);
					default: beat.item_priority = ($urandom_range(0, 1) != 0) ?
						{PRIO_W{1'b1}} : PRIO_W'($urandom_range(0, 1));
				endcase
				send_beat(beat);
			end
			n_items -= run_len;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_underflow();
		test_fill_to_full();
		test_random_traffic(1030);
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_datapath.sv
sv/stable_priority_queue.sv
sim/testbench.sv
